@@ rtl/f2h_pkg.sv @@
// Package with the field widths and constants of the float to half projection.
package f2h_pkg;

    localparam int unsigned Exp32Bias   = 127;
    localparam int unsigned MaxBexp     = 142;
    localparam int unsigned MinSubBexp  = 103;
    localparam int unsigned MinNormBexp = 113;
    localparam logic [7:0]  Rebias      = 8'd112;

    typedef enum logic
    {
        STATUS_OK      = 1'b0,
        STATUS_TOO_BIG = 1'b1
    } status_t;

    typedef struct packed
    {
        logic [15:0] half_bits;
        status_t     status;
    } half_res_t;

endpackage

@@ rtl/float_to_half_projection.sv @@
// Top level of the float to half projection with its input and result registers.
//
// A request is taken at every rising edge at which start is high; busy is
// always low, so one request may follow another in every cycle.
// The binary32 pattern goes into an input register; the next cycle the
// truncating projection and the exact widening are computed and stored in
// the result register. Results appear from the result register,
// on projected_bits, half_bits and status, for exactly one cycle with done high.
// Throughput is one request per cycle, set by the single pass of logic
// between the two registers.
// A too big, infinite or NaN input gives status 1 and zero patterns.
// Reset clears the valid flags, so no result is shown after reset until a
// request arrives. The receiver cannot stall; results are not held.
module float_to_half_projection
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] single_bits,
    output logic        done,
    output logic [31:0] projected_bits,
    output logic [15:0] half_bits,
    output logic        status
);

    logic               in_valid_reg;
    logic [31:0]        in_bits_reg;
    logic               out_valid_reg;
    logic [31:0]        proj_reg;
    f2h_pkg::half_res_t res_reg;
    f2h_pkg::half_res_t res_next;
    logic [31:0]        proj_next;

    f2h_narrow u_narrow
    (
        .single_bits (in_bits_reg),
        .res         (res_next)
    );

    f2h_widen u_widen
    (
        .half_bits      (res_next.half_bits),
        .projected_bits (proj_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_bits_reg <= single_bits;
        end
        if (in_valid_reg)
        begin
            res_reg  <= res_next;
            proj_reg <= (res_next.status == f2h_pkg::STATUS_TOO_BIG) ? 32'd0 : proj_next;
        end
    end

    assign busy           = 1'b0;
    assign done           = out_valid_reg;
    assign projected_bits = proj_reg;
    assign half_bits      = res_reg.half_bits;
    assign status         = res_reg.status;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("Result did not follow a request after two cycles.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("Result without a request.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (half_bits == 16'd0 && projected_bits == 32'd0))
        else $error("Error result with nonzero patterns.");

endmodule

@@ rtl/f2h_narrow.sv @@
// Combinational projection of a binary32 pattern onto a truncated binary16 pattern.
module f2h_narrow
(
    input  logic [31:0]        single_bits,
    output f2h_pkg::half_res_t res
);

    logic        sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [3:0]  k;
    logic [10:0] sub_frac;

    always_comb
    begin
        sgn      = single_bits[31];
        bexp     = single_bits[30:23];
        frac     = single_bits[22:0];
        k        = 4'(8'(f2h_pkg::MinNormBexp) - bexp);
        sub_frac = (11'd1 << (4'd10 - k)) + 11'(frac >> (5'd13 + 5'(k)));
        res.status    = f2h_pkg::STATUS_OK;
        res.half_bits = 16'd0;
        if (bexp > 8'(f2h_pkg::MaxBexp))
        begin
            res.status = f2h_pkg::STATUS_TOO_BIG;
        end
        else if (bexp < 8'(f2h_pkg::MinSubBexp))
        begin
            res.half_bits = 16'd0;
        end
        else if (bexp < 8'(f2h_pkg::MinNormBexp))
        begin
            res.half_bits = {sgn, 5'd0, sub_frac[9:0]};
        end
        else
        begin
            res.half_bits = {sgn, 5'(bexp - 8'(f2h_pkg::MinNormBexp) + 8'd1), frac[22:13]};
        end
    end

endmodule

@@ rtl/f2h_widen.sv @@
// Combinational exact widening of a binary16 pattern to binary32.
module f2h_widen
(
    input  logic [15:0] half_bits,
    output logic [31:0] projected_bits
);

    logic [4:0]  hexp;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [22:0] shifted;

    always_comb
    begin
        hexp = half_bits[14:10];
        m    = half_bits[9:0];
        p    = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
            begin
                p = 4'(i);
            end
        end
        shifted = 23'({m, 13'd0} << (4'd10 - p));
        if (hexp == 5'd0)
        begin
            if (m == 10'd0)
            begin
                projected_bits = {half_bits[15], 31'd0};
            end
            else
            begin
                projected_bits = {half_bits[15], 8'(p) + 8'(f2h_pkg::MinSubBexp), shifted};
            end
        end
        else
        begin
            projected_bits = {half_bits[15], 8'(hexp) + f2h_pkg::Rebias, m, 13'd0};
        end
    end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench of the float to half projection: directed table, then random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000;
    localparam int RandomCount = 1950;

    typedef struct packed
    {
        logic [31:0]      projected_bits;
        logic [15:0]      half_bits;
        f2h_pkg::status_t status;
    } projection_t;

    typedef struct
    {
        logic [31:0] single_bits;
        logic        typed;
        projection_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] single_bits = '0;
    logic        done;
    logic [31:0] projected_bits;
    logic [15:0] half_bits;
    logic        status;

    projection_t pending_projections[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          sender_idle_pct = 0;

    float_to_half_projection DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .single_bits(single_bits),
        .done(done),
        .projected_bits(projected_bits),
        .half_bits(half_bits),
        .status(status)
    );

    always #4 clk = ~clk;

    function automatic projection_t project_single(logic [31:0] w);
        projection_t r;
        int          e;
        int          k;
        int          p;
        logic [9:0]  m;
        logic [15:0] h;
        e = int'(w[30:23]) - 127;
        r = '0;
        r.status = f2h_pkg::STATUS_OK;
        if (e > 15)
        begin
            r.status = f2h_pkg::STATUS_TOO_BIG;
            return r;
        end
        if (e < -24)
            return r;
        if (e < -14)
        begin
            k = -14 - e;
            m = 10'((32'd1 << (10 - k)) + (32'(w[22:0]) >> (13 + k)));
            h = {w[31], 5'd0, m};
        end
        else
        begin
            m = w[22:13];
            h = {w[31], 5'(e + 15), m};
        end
        r.half_bits = h;
        if (h[14:10] == 5'd0)
        begin
            if (m == 10'd0)
                r.projected_bits = {h[15], 31'd0};
            else
            begin
                p = 9;
                while (!m[p])
                    p--;
                r.projected_bits = {h[15], 8'(p + 103), 23'((32'(m) << (23 - p)) & 32'h7FFFFF)};
            end
        end
        else
            r.projected_bits = {h[15], 8'(h[14:10]) + 8'd112, m, 13'd0};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        projection_t exp_r;
        if (rst_n && done)
        begin
            if (pending_projections.size() == 0)
                report_mismatch("unexpected result", projected_bits, 32'd0);
            else
            begin
                exp_r = pending_projections.pop_front();
                if (projected_bits !== exp_r.projected_bits)
                    report_mismatch("projected_bits", projected_bits, exp_r.projected_bits);
                if (half_bits !== exp_r.half_bits)
                    report_mismatch("half_bits", 32'(half_bits), 32'(exp_r.half_bits));
                if (status !== exp_r.status)
                    report_mismatch("status", 32'(status), 32'(exp_r.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(logic [31:0] w, logic typed, projection_t want);
        projection_t pred;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        single_bits <= w;
        pred = project_single(w);
        if (typed && pred !== want)
            report_mismatch("table row", 32'(pred), 32'(want));
        pending_projections.push_back(typed ? want : pred);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_single();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(3) != 0)
            w[30:23] = 8'($urandom_range(98, 146));
        return w;
    endfunction

    stim_row_t stim_table[] = '{
        '{32'h0000_0000, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_OK}},
        '{32'h8000_0000, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_OK}},
        '{32'h0000_0001, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_OK}},
        '{32'h807F_FFFF, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_OK}},
        '{32'h3F80_0000, 1'b1, '{32'h3F80_0000, 16'h3C00, f2h_pkg::STATUS_OK}},
        '{32'hBF80_0000, 1'b1, '{32'hBF80_0000, 16'hBC00, f2h_pkg::STATUS_OK}},
        '{32'h7F80_0000, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_TOO_BIG}},
        '{32'hFF80_0000, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_TOO_BIG}},
        '{32'h7FC0_0001, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_TOO_BIG}},
        '{32'h4780_0000, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_TOO_BIG}},
        '{32'h477F_FFFF, 1'b1, '{32'h477F_E000, 16'h7BFF, f2h_pkg::STATUS_OK}},
        '{32'hC77F_FFFF, 1'b1, '{32'hC77F_E000, 16'hFBFF, f2h_pkg::STATUS_OK}},
        '{32'h3880_0000, 1'b1, '{32'h3880_0000, 16'h0400, f2h_pkg::STATUS_OK}},
        '{32'h3380_0000, 1'b1, '{32'h3380_0000, 16'h0001, f2h_pkg::STATUS_OK}},
        '{32'hB3FF_FFFF, 1'b1, '{32'hB380_0000, 16'h8001, f2h_pkg::STATUS_OK}},
        '{32'h337F_FFFF, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_OK}},
        '{32'h387F_FFFF, 1'b0, '{32'h0, 16'h0, f2h_pkg::STATUS_OK}},
        '{32'h3800_0000, 1'b0, '{32'h0, 16'h0, f2h_pkg::STATUS_OK}},
        '{32'hB6AA_AAAA, 1'b0, '{32'h0, 16'h0, f2h_pkg::STATUS_OK}},
        '{32'h3555_5555, 1'b0, '{32'h0, 16'h0, f2h_pkg::STATUS_OK}},
        '{32'h4255_5555, 1'b0, '{32'h0, 16'h0, f2h_pkg::STATUS_OK}},
        '{32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 16'h0000, f2h_pkg::STATUS_TOO_BIG}}
    };

    initial
    begin
        int phase_pct[4];
        phase_pct = '{0, 76, 0, 7};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_table[i])
            send_request(stim_table[i].single_bits, stim_table[i].typed, stim_table[i].want);
        start <= 1'b0;
        while (pending_projections.size() != 0)
            @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = phase_pct[ph];
            for (int n = 0; n < RandomCount / 4; n++)
                send_request(random_single(), 1'b0, '0);
            start <= 1'b0;
            while (pending_projections.size() != 0)
                @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_projections.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
